// ----- design/ilcs_pkg.sv -----
`default_nettype none
package ilcs_pkg;

    localparam logic [7:0] PROTO_ICMP = 8'h01;
    localparam logic [7:0] PROTO_TCP  = 8'h06;
    localparam logic [7:0] PROTO_UDP  = 8'h11;

    localparam logic [3:0] MIN_IHL = 4'd5;

    // word positions inside the IPv4 header
    localparam logic [15:0] W_VER_IHL  = 16'd0;
    localparam logic [15:0] W_TOT_LEN  = 16'd1;
    localparam logic [15:0] W_PROTO    = 16'd4;
    localparam logic [15:0] W_HDR_CSUM = 16'd5;
    localparam logic [15:0] W_SRC_HI   = 16'd6;
    localparam logic [15:0] W_DST_LO   = 16'd9;
    localparam logic [15:0] W_MAX      = 16'hffff;

    // word positions inside the transport header
    localparam logic [15:0] T_UDP_LEN  = 16'd2;
    localparam logic [15:0] T_UDP_CSUM = 16'd3;
    localparam logic [15:0] T_TCP_CSUM = 16'd8;

    localparam logic [16:0] BYTES_MAX  = 17'h1ffff;
    localparam logic [16:0] UDP_HDR_TO_LEN = 17'd6;

    typedef enum logic [2:0] {
        STAT_TCP_DONE  = 3'd0,
        STAT_UDP_DONE  = 3'd1,
        STAT_ICMP_SKIP = 3'd2,
        STAT_UNHANDLED = 3'd3,
        STAT_TRUNCATED = 3'd4
    } status_t;

    // packet totals handed over on the last word
    typedef struct packed {
        logic [20:0] header_sum;
        logic [31:0] transport_sum;
        logic [3:0]  header_words;
        logic [15:0] total_length;
        logic [7:0]  protocol_number;
        logic [15:0] transport_length;
        logic [16:0] bytes_seen;
        logic [15:0] udp_port0;
        logic [15:0] udp_port1;
    } totals_t;

    typedef struct packed {
        logic [20:0] header_sum;
        logic        header_complete;
        logic [31:0] l4_sum;
        status_t     status;
    } sums_t;

    // bytes of transport word t that lie inside len
    function automatic logic [15:0] in_length(input logic [15:0] d, input logic [15:0] t,
                                              input logic [15:0] len);
        logic [16:0] b0;
        logic [16:0] b1;
        logic [15:0] v;
        b0 = {t, 1'b0};
        b1 = {t, 1'b1};
        v  = '0;
        if (b0 < {1'b0, len}) v[15:8] = d[15:8];
        if (b1 < {1'b0, len}) v[7:0] = d[7:0];
        return v;
    endfunction

    function automatic logic [15:0] fold_not(input logic [31:0] s);
        logic [16:0] s1;
        logic [15:0] s2;
        s1 = {1'b0, s[15:0]} + {1'b0, s[31:16]};
        s2 = s1[15:0] + {15'b0, s1[16]};
        return ~s2;
    endfunction

endpackage
`default_nettype wire

// ----- design/ipv4_l4_checksum_engine.sv -----
// IPv4 header and TCP/UDP checksum engine.
// s_ channel: one 16-bit packet word per item, big-endian, starting at the IP header.
//   s_tuser carries the count of valid bytes (1 = upper byte only), s_tlast ends the packet.
// m_ channel: one item per packet, issued for the word marked last. m_tdata holds the
//   IP header checksum (low half) and the TCP/UDP checksum (high half); m_tuser holds
//   the status: TCP done, UDP done, ICMP skipped, unhandled protocol or truncated.
// Throughput: one word per clock, back to back, across packet boundaries, unless a held-low m_tready fills the stages.
// The result passes three register stages in order: the word sum, then the
//   pseudo-header sum and length checks, then the fold.
// Reset (aresetn low, synchronous) empties the pipeline and clears the packet totals.
// When m_tready is held low, the three stages fill and s_tready drops; no item is lost.
`default_nettype none
module ipv4_l4_checksum_engine (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] data_word
    input  wire logic [1:0]  s_tuser,   // [1:0] valid_bytes
    input  wire logic        s_tlast,   // last_word
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] ip_header_checksum, [31:16] l4_checksum
    output logic [2:0]       m_tuser    // [2:0] status
);
    import ilcs_pkg::*;

    logic    word_accept;
    logic    tot_valid, tot_ready;
    totals_t tot;
    logic    sums_valid, sums_ready;
    sums_t   sums;

    assign s_tready    = !tot_valid || tot_ready;
    assign word_accept = s_tvalid && s_tready;

    ilcs_accum u_accum (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .word_accept      (word_accept),
        .word_data        (s_tdata),
        .word_valid_bytes (s_tuser),
        .word_last        (s_tlast),
        .tot_ready        (tot_ready),
        .tot_valid        (tot_valid),
        .tot              (tot)
    );

    ilcs_sum u_sum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tot_valid  (tot_valid),
        .tot        (tot),
        .tot_ready  (tot_ready),
        .sums_ready (sums_ready),
        .sums_valid (sums_valid),
        .sums       (sums)
    );

    ilcs_fold u_fold (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .sums_valid  (sums_valid),
        .sums        (sums),
        .sums_ready  (sums_ready),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_ip_csum (m_tdata[15:0]),
        .res_l4_csum (m_tdata[31:16]),
        .res_status  (m_tuser)
    );

    // input only stalls once every stage holds a result
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled with room in the pipeline");

    a_l4_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != STAT_TCP_DONE && m_tuser != STAT_UDP_DONE)
            |-> (m_tdata[31:16] == 16'h0000))
        else $error("transport checksum set for a packet without one");

    a_udp_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STAT_UDP_DONE) |-> (m_tdata[31:16] != 16'h0000))
        else $error("UDP checksum of zero emitted");

    a_last_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> tot_valid)
        else $error("last word gave no packet totals");

endmodule
`default_nettype wire

// ----- design/ilcs_accum.sv -----
`default_nettype none
module ilcs_accum (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            word_accept,
    input  wire logic [15:0]     word_data,
    input  wire logic [1:0]      word_valid_bytes,
    input  wire logic            word_last,
    input  wire logic            tot_ready,
    output logic                 tot_valid,
    output ilcs_pkg::totals_t    tot
);
    import ilcs_pkg::*;

    logic [15:0] word_index_reg, word_index_next;
    logic [3:0]  header_words_reg, header_words_next;
    logic [15:0] total_length_reg, total_length_next;
    logic [7:0]  protocol_reg, protocol_next;
    logic [20:0] header_sum_reg, header_sum_next;
    logic [31:0] transport_sum_reg, transport_sum_next;
    logic [15:0] transport_length_reg, transport_length_next;
    logic [16:0] bytes_seen_next;
    logic [15:0] udp_port0_reg, udp_port0_next;
    logic [15:0] udp_port1_reg, udp_port1_next;
    logic        tot_valid_reg;
    totals_t     tot_reg;

    logic [15:0] d;
    logic        single;
    logic [4:0]  hdrw;
    logic [15:0] t;
    logic [17:0] end_bytes;

    always_comb begin
        single = (word_valid_bytes == 2'd1);
        d      = single ? {word_data[15:8], 8'h00} : word_data;

        header_words_next     = header_words_reg;
        total_length_next     = total_length_reg;
        protocol_next         = protocol_reg;
        header_sum_next       = header_sum_reg;
        transport_sum_next    = transport_sum_reg;
        transport_length_next = transport_length_reg;
        udp_port0_next        = udp_port0_reg;
        udp_port1_next        = udp_port1_reg;

        if (word_index_reg == W_VER_IHL) begin
            header_words_next = (d[11:8] < MIN_IHL) ? MIN_IHL : d[11:8];
        end
        if (word_index_reg == W_TOT_LEN) begin
            total_length_next = d;
        end
        if (word_index_reg == W_PROTO) begin
            protocol_next = d[7:0];
            if (d[7:0] == PROTO_TCP) begin
                transport_length_next = total_length_reg - {10'b0, header_words_next, 2'b00};
            end
        end

        hdrw = {header_words_next, 1'b0};
        t    = word_index_reg - {11'b0, hdrw};

        if (word_index_reg < {11'b0, hdrw}) begin
            if (word_index_reg != W_HDR_CSUM) begin
                header_sum_next = header_sum_reg + {5'b0, d};
            end
            if (word_index_reg >= W_SRC_HI && word_index_reg <= W_DST_LO) begin
                transport_sum_next = transport_sum_reg + {16'b0, d};
            end
        end else if (protocol_next == PROTO_TCP) begin
            if (t != T_TCP_CSUM) begin
                transport_sum_next = transport_sum_reg
                                   + {16'b0, in_length(d, t, transport_length_next)};
            end
        end else if (protocol_next == PROTO_UDP) begin
            if (t < T_UDP_LEN) begin
                if (t[0]) udp_port1_next = d;
                else      udp_port0_next = d;
            end else begin
                if (t == T_UDP_LEN) transport_length_next = d;
                if (t != T_UDP_CSUM) begin
                    transport_sum_next = transport_sum_reg
                                       + {16'b0, in_length(d, t, transport_length_next)};
                end
            end
        end

        end_bytes       = {1'b0, word_index_reg, 1'b0} + (single ? 18'd1 : 18'd2);
        bytes_seen_next = (end_bytes > {1'b0, BYTES_MAX}) ? BYTES_MAX : end_bytes[16:0];
        word_index_next = (word_index_reg != W_MAX) ? word_index_reg + 16'd1 : word_index_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_index_reg       <= '0;
            header_words_reg     <= '0;
            total_length_reg     <= '0;
            protocol_reg         <= '0;
            header_sum_reg       <= '0;
            transport_sum_reg    <= '0;
            transport_length_reg <= '0;
            udp_port0_reg        <= '0;
            udp_port1_reg        <= '0;
            tot_valid_reg        <= 1'b0;
        end else begin
            if (word_accept && word_last) begin
                tot_valid_reg <= 1'b1;
            end else if (tot_ready) begin
                tot_valid_reg <= 1'b0;
            end
            if (word_accept) begin
                if (word_last) begin
                    word_index_reg       <= '0;
                    header_words_reg     <= '0;
                    total_length_reg     <= '0;
                    protocol_reg         <= '0;
                    header_sum_reg       <= '0;
                    transport_sum_reg    <= '0;
                    transport_length_reg <= '0;
                    udp_port0_reg        <= '0;
                    udp_port1_reg        <= '0;
                end else begin
                    word_index_reg       <= word_index_next;
                    header_words_reg     <= header_words_next;
                    total_length_reg     <= total_length_next;
                    protocol_reg         <= protocol_next;
                    header_sum_reg       <= header_sum_next;
                    transport_sum_reg    <= transport_sum_next;
                    transport_length_reg <= transport_length_next;
                    udp_port0_reg        <= udp_port0_next;
                    udp_port1_reg        <= udp_port1_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (word_accept && word_last) begin
            tot_reg.header_sum       <= header_sum_next;
            tot_reg.transport_sum    <= transport_sum_next;
            tot_reg.header_words     <= header_words_next;
            tot_reg.total_length     <= total_length_next;
            tot_reg.protocol_number  <= protocol_next;
            tot_reg.transport_length <= transport_length_next;
            tot_reg.bytes_seen       <= bytes_seen_next;
            tot_reg.udp_port0        <= udp_port0_next;
            tot_reg.udp_port1        <= udp_port1_next;
        end
    end

    assign tot_valid = tot_valid_reg;
    assign tot       = tot_reg;

endmodule
`default_nettype wire

// ----- design/ilcs_sum.sv -----
`default_nettype none
module ilcs_sum (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               tot_valid,
    input  wire ilcs_pkg::totals_t  tot,
    output logic                    tot_ready,
    input  wire logic               sums_ready,
    output logic                    sums_valid,
    output ilcs_pkg::sums_t         sums
);
    import ilcs_pkg::*;

    logic        sums_valid_reg;
    sums_t       sums_reg, sums_next;
    logic [16:0] hb;
    logic [16:0] hb_tl;
    logic        trunc;
    logic [31:0] base_sum;

    always_comb begin
        hb       = {11'b0, tot.header_words, 2'b00};
        hb_tl    = hb + {1'b0, tot.transport_length};
        trunc    = (tot.bytes_seen < hb) || (tot.bytes_seen < {1'b0, tot.total_length});
        base_sum = tot.transport_sum + {24'b0, tot.protocol_number}
                 + {16'b0, tot.transport_length};

        sums_next.header_sum      = tot.header_sum;
        sums_next.header_complete = (tot.bytes_seen >= hb);
        sums_next.l4_sum          = base_sum;

        if (tot.protocol_number == PROTO_TCP) begin
            if (tot.bytes_seen < hb_tl) trunc = 1'b1;
        end else if (tot.protocol_number == PROTO_UDP) begin
            if (tot.bytes_seen < hb + UDP_HDR_TO_LEN || tot.bytes_seen < hb_tl) trunc = 1'b1;
            sums_next.l4_sum = base_sum
                + {16'b0, in_length(tot.udp_port0, 16'd0, tot.transport_length)}
                + {16'b0, in_length(tot.udp_port1, 16'd1, tot.transport_length)};
        end

        if (trunc)                                   sums_next.status = STAT_TRUNCATED;
        else if (tot.protocol_number == PROTO_TCP)   sums_next.status = STAT_TCP_DONE;
        else if (tot.protocol_number == PROTO_UDP)   sums_next.status = STAT_UDP_DONE;
        else if (tot.protocol_number == PROTO_ICMP)  sums_next.status = STAT_ICMP_SKIP;
        else                                         sums_next.status = STAT_UNHANDLED;
    end

    assign tot_ready = !sums_valid_reg || sums_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sums_valid_reg <= 1'b0;
        end else if (tot_ready) begin
            sums_valid_reg <= tot_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (tot_ready && tot_valid) begin
            sums_reg <= sums_next;
        end
    end

    assign sums_valid = sums_valid_reg;
    assign sums       = sums_reg;

endmodule
`default_nettype wire

// ----- design/ilcs_fold.sv -----
`default_nettype none
module ilcs_fold (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             sums_valid,
    input  wire ilcs_pkg::sums_t  sums,
    output logic                  sums_ready,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output logic [15:0]           res_ip_csum,
    output logic [15:0]           res_l4_csum,
    output logic [2:0]            res_status
);
    import ilcs_pkg::*;

    logic        res_valid_reg;
    logic [15:0] ip_csum_reg, ip_csum_next;
    logic [15:0] l4_csum_reg, l4_csum_next;
    logic [2:0]  status_reg;
    logic [15:0] l4_fold;

    always_comb begin
        ip_csum_next = sums.header_complete ? fold_not({11'b0, sums.header_sum}) : 16'h0000;
        l4_fold      = fold_not(sums.l4_sum);
        case (sums.status)
            STAT_TCP_DONE: l4_csum_next = l4_fold;
            STAT_UDP_DONE: l4_csum_next = (l4_fold == 16'h0000) ? 16'hffff : l4_fold;
            default:       l4_csum_next = 16'h0000;
        endcase
    end

    assign sums_ready = !res_valid_reg || res_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (sums_ready) begin
            res_valid_reg <= sums_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (sums_ready && sums_valid) begin
            ip_csum_reg <= ip_csum_next;
            l4_csum_reg <= l4_csum_next;
            status_reg  <= sums.status;
        end
    end

    assign res_valid   = res_valid_reg;
    assign res_ip_csum = ip_csum_reg;
    assign res_l4_csum = l4_csum_reg;
    assign res_status  = status_reg;

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ilcs_pkg::*;

    typedef struct packed {
        logic [15:0] ipcs;
        logic [15:0] l4;
        status_t     status;
    } csum_result_t;

    typedef struct packed {
        logic [15:0]  data;
        logic [1:0]   vbytes;
        logic         last;
        logic         typed;
        csum_result_t exp;
    } pkt_item_t;

    localparam csum_result_t NO_EXP = '{16'h0000, 16'h0000, STAT_TCP_DONE};

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    ipv4_l4_checksum_engine DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // directed packets: truncated single word, ICMP with short IHL, minimal UDP
    pkt_item_t directed_rows [25] = '{
        '{16'hffff, 2'd0, 1'b1, 1'b1, '{16'h0000, 16'h0000, STAT_TRUNCATED}},
        '{16'h4000, 2'd2, 1'b0, 1'b0, NO_EXP},
        '{16'h0014, 2'd3, 1'b0, 1'b0, NO_EXP},
        '{16'h0000, 2'd2, 1'b0, 1'b0, NO_EXP},
        '{16'h0000, 2'd2, 1'b0, 1'b0, NO_EXP},
        '{16'h4001, 2'd2, 1'b0, 1'b0, NO_EXP},
        '{16'hffff, 2'd2, 1'b0, 1'b0, NO_EXP},
        '{16'h0000, 2'd2, 1'b0, 1'b0, NO_EXP},
        '{16'h0000, 2'd2, 1'b0, 1'b0, NO_EXP},
        '{16'h0000, 2'd2, 1'b0, 1'b0, NO_EXP},
        '{16'h0000, 2'd2, 1'b1, 1'b1, '{16'h7fea, 16'h0000, STAT_ICMP_SKIP}},
        '{16'h4500, 2'd2, 1'b0, 1'b0, NO_EXP},
        '{16'h001c, 2'd2, 1'b0, 1'b0, NO_EXP},
        '{16'h0000, 2'd2, 1'b0, 1'b0, NO_EXP},
        '{16'h0000, 2'd2, 1'b0, 1'b0, NO_EXP},
        '{16'h4011, 2'd2, 1'b0, 1'b0, NO_EXP},
        '{16'h0000, 2'd2, 1'b0, 1'b0, NO_EXP},
        '{16'hffff, 2'd2, 1'b0, 1'b0, NO_EXP},
        '{16'hffff, 2'd2, 1'b0, 1'b0, NO_EXP},
        '{16'hffff, 2'd2, 1'b0, 1'b0, NO_EXP},
        '{16'hffff, 2'd2, 1'b0, 1'b0, NO_EXP},
        '{16'hffff, 2'd2, 1'b0, 1'b0, NO_EXP},
        '{16'hffff, 2'd2, 1'b0, 1'b0, NO_EXP},
        '{16'h0008, 2'd2, 1'b0, 1'b0, NO_EXP},
        '{16'h0000, 2'd0, 1'b1, 1'b0, NO_EXP}
    };

    pkt_item_t    stim_q[$];
    pkt_item_t    drv_item;
    csum_result_t expected_sums[$];
    int           mismatch_count = 0;

    // predictor state
    logic [15:0] wd_idx;
    logic [3:0]  ihl_eff;
    logic [15:0] ip_tot_len;
    logic [7:0]  ip_proto;
    logic [20:0] hdr_acc;
    logic [31:0] l4_acc;
    logic [15:0] l4_len;
    logic [16:0] byte_cnt;
    logic [15:0] udp_port [2];

    task automatic restart_packet();
        wd_idx      = '0;
        ihl_eff     = '0;
        ip_tot_len  = '0;
        ip_proto    = '0;
        hdr_acc     = '0;
        l4_acc      = '0;
        l4_len      = '0;
        byte_cnt    = '0;
        udp_port[0] = '0;
        udp_port[1] = '0;
    endtask

    function automatic logic [15:0] len_masked(input logic [15:0] d, input int unsigned t,
                                               input logic [15:0] len);
        logic [15:0] v;
        v = '0;
        if (t * 2 < len) v[15:8] = d[15:8];
        if (t * 2 + 1 < len) v[7:0] = d[7:0];
        return v;
    endfunction

    function automatic logic [15:0] fold_complement(input logic [31:0] s);
        logic [31:0] a;
        a = s;
        while (a[31:16] != 16'd0) a = {16'd0, a[15:0]} + {16'd0, a[31:16]};
        return ~a[15:0];
    endfunction

    task automatic predict_word(input logic [15:0] d_in, input logic [1:0] vb, input logic last,
                                output bit produced, output csum_result_t res);
        logic [15:0] d;
        logic [31:0] s;
        int unsigned nb;
        int unsigned w;
        int unsigned hw2;
        int unsigned t;
        int unsigned hb;
        int unsigned e;
        bit          trunc;
        d = d_in;
        nb = (vb == 2'd1) ? 1 : 2;
        if (nb == 1) d[7:0] = 8'h00;
        w = wd_idx;
        produced = 1'b0;
        res = NO_EXP;
        if (w == W_VER_IHL) ihl_eff = (d[11:8] < MIN_IHL) ? MIN_IHL : d[11:8];
        if (w == W_TOT_LEN) ip_tot_len = d;
        if (w == W_PROTO) begin
            ip_proto = d[7:0];
            if (ip_proto == PROTO_TCP) l4_len = ip_tot_len - {10'd0, ihl_eff, 2'b00};
        end
        hw2 = ihl_eff * 2;
        if (w < hw2) begin
            if (w != W_HDR_CSUM) hdr_acc += 21'(d);
            if (w >= W_SRC_HI && w <= W_DST_LO) l4_acc += 32'(d);
        end else begin
            t = w - hw2;
            if (ip_proto == PROTO_TCP) begin
                if (t != T_TCP_CSUM) l4_acc += 32'(len_masked(d, t, l4_len));
            end else if (ip_proto == PROTO_UDP) begin
                if (t < 2) begin
                    udp_port[t] = d;
                end else begin
                    if (t == T_UDP_LEN) l4_len = d;
                    if (t != T_UDP_CSUM) l4_acc += 32'(len_masked(d, t, l4_len));
                end
            end
        end
        e = w * 2 + nb;
        byte_cnt = (e > BYTES_MAX) ? BYTES_MAX : e[16:0];
        if (w < W_MAX) wd_idx = 16'(w + 1);
        if (last) begin
            hb = ihl_eff * 4;
            res.ipcs = (byte_cnt >= hb) ? fold_complement({11'd0, hdr_acc}) : 16'h0000;
            trunc = (byte_cnt < hb) || (byte_cnt < ip_tot_len);
            if (ip_proto == PROTO_TCP) begin
                if (byte_cnt < hb + l4_len) trunc = 1'b1;
            end else if (ip_proto == PROTO_UDP) begin
                if (byte_cnt < hb + UDP_HDR_TO_LEN || byte_cnt < hb + l4_len) trunc = 1'b1;
            end
            if (trunc) begin
                res.status = STAT_TRUNCATED;
            end else if (ip_proto == PROTO_TCP) begin
                res.status = STAT_TCP_DONE;
                res.l4 = fold_complement(l4_acc + 32'(ip_proto) + 32'(l4_len));
            end else if (ip_proto == PROTO_UDP) begin
                s = l4_acc + 32'(ip_proto) + 32'(l4_len);
                s += 32'(len_masked(udp_port[0], 0, l4_len));
                s += 32'(len_masked(udp_port[1], 1, l4_len));
                res.status = STAT_UDP_DONE;
                res.l4 = fold_complement(s);
                if (res.l4 == 16'h0000) res.l4 = 16'hffff;
            end else if (ip_proto == PROTO_ICMP) begin
                res.status = STAT_ICMP_SKIP;
            end else begin
                res.status = STAT_UNHANDLED;
            end
            produced = 1'b1;
            restart_packet();
        end
    endtask

    // builds one packet as bytes, then splits it into words, or queues random words; a few are damaged on purpose
    task automatic queue_packet(input bit longest);
        logic [7:0] b[$];
        logic [7:0] proto;
        pkt_item_t  it;
        int         pick;
        int         ihl;
        int         hdr_bytes;
        int         body_bytes;
        int         pad;
        int         total;
        int         fault;
        int         single_at;
        int         nw;
        int         r;
        int         i;
        pick = $urandom_range(0, 99);
        if (!longest && pick < 8) begin
            nw = $urandom_range(1, 12);
            for (i = 0; i < nw; i++) begin
                it = '0;
                it.data = 16'($urandom);
                it.vbytes = 2'($urandom);
                it.last = (i == nw - 1);
                stim_q.push_back(it);
            end
            return;
        end
        proto = pick < 36 ? PROTO_TCP : pick < 68 ? PROTO_UDP : pick < 82 ? PROTO_ICMP
                : 8'($urandom);
        ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
        pad = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 0;
        if (longest) begin
            proto = PROTO_TCP;
            ihl = 5;
            pad = 0;
        end
        hdr_bytes = (ihl < 5 ? 5 : ihl) * 4;
        if (longest)
            body_bytes = 131074 - hdr_bytes;
        else if (proto == PROTO_TCP)
            body_bytes = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 19)
                         : $urandom_range(20, 56);
        else if (proto == PROTO_UDP)
            body_bytes = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                         : $urandom_range(8, 40);
        else
            body_bytes = $urandom_range(0, 24);
        total = longest ? 16'hffff : hdr_bytes + body_bytes + (proto == PROTO_UDP ? pad : 0);
        for (i = 0; i < hdr_bytes + body_bytes + pad; i++) b.push_back(8'($urandom));
        b[0] = {4'h4, 4'(ihl)};
        b[9] = proto;
        if (proto == PROTO_UDP && body_bytes >= 6) begin
            b[hdr_bytes + 4] = 8'(body_bytes >> 8);
            b[hdr_bytes + 5] = 8'(body_bytes);
        end
        fault = longest ? 99 : $urandom_range(0, 99);
        if (fault < 6 && b.size() > 1) begin
            r = $urandom_range(1, b.size() - 1);
            while (b.size() > r) void'(b.pop_back());
        end else if (fault >= 6 && fault < 11) begin
            total = $urandom_range(0, 1) ? $urandom_range(0, hdr_bytes - 1) : 16'($urandom);
        end
        if (b.size() > 3) begin
            b[2] = 8'(total >> 8);
            b[3] = 8'(total);
        end
        nw = (b.size() + 1) / 2;
        single_at = (fault >= 11 && fault < 15 && nw > 1) ? $urandom_range(0, nw - 2) : -1;
        for (i = 0; i < nw; i++) begin
            it = '0;
            it.data = {b[2 * i], (2 * i + 1 < b.size()) ? b[2 * i + 1] : 8'($urandom)};
            it.last = (i == nw - 1);
            if (2 * i + 1 >= b.size() || i == single_at) begin
                it.vbytes = 2'd1;
            end else begin
                r = $urandom_range(0, 2);
                it.vbytes = (r == 0) ? 2'd0 : 2'(r + 1);
            end
            stim_q.push_back(it);
        end
    endtask

    task automatic note_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("MISMATCH at %0t ns: %s expected %h got %h", $time, what, want, got);
    endtask

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin : monitor
        csum_result_t pred;
        csum_result_t want;
        csum_result_t got;
        bit           done;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_word(s_tdata, s_tuser, s_tlast, done, pred);
                if (done) expected_sums.push_back(drv_item.typed ? drv_item.exp : pred);
            end
            if (m_tvalid && m_tready) begin
                got.ipcs = m_tdata[15:0];
                got.l4 = m_tdata[31:16];
                got.status = status_t'(m_tuser);
                if (expected_sums.size() == 0) begin
                    note_mismatch("result with no packet pending", 16'h0000, got.ipcs);
                end else begin
                    want = expected_sums.pop_front();
                    if (got.ipcs !== want.ipcs)
                        note_mismatch("ip header checksum", want.ipcs, got.ipcs);
                    if (got.l4 !== want.l4)
                        note_mismatch("l4 checksum", want.l4, got.l4);
                    if (got.status !== want.status)
                        note_mismatch("status", {13'd0, want.status}, {13'd0, got.status});
                end
            end
        end
    end

    // receiver: rotating ready mask, re-drawn whenever its random span runs out
    initial begin : sink
        logic [15:0] mask;
        int          span;
        m_tready = 1'b0;
        mask = 16'hffff;
        span = 0;
        forever begin
            @(negedge aclk);
            if (span == 0) begin
                span = $urandom_range(16, 96);
                mask = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
            end
            m_tready = mask[0];
            mask = {mask[0], mask[15:1]};
            span--;
        end
    end

    initial begin : stimulus
        int burst;
        int gap;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        drv_item = '0;
        restart_packet();
        foreach (directed_rows[k]) stim_q.push_back(directed_rows[k]);
        while (stim_q.size() < 500) queue_packet(1'b0);
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        while (stim_q.size() != 0) begin
            burst = $urandom_range(1, 24);
            while (burst != 0 && stim_q.size() != 0) begin
                drv_item = stim_q.pop_front();
                s_tvalid = 1'b1;
                s_tdata = drv_item.data;
                s_tuser = drv_item.vbytes;
                s_tlast = drv_item.last;
                do @(posedge aclk); while (s_tready !== 1'b1);
                @(negedge aclk);
                burst--;
            end
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_tvalid = 1'b0;
        while (expected_sums.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #30_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
